### src/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define AST_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Implication checked on the next edge.
`define AST_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### src/oaht_pkg.sv
// Shared types, codes and helpers of the open-address hash table.
// Used by every module of the block; depends on nothing.
package oaht_pkg;
	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SIZE_W = 8;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;

	localparam logic [1:0] FLAG_EMPTY = 2'd0;
	localparam logic [1:0] FLAG_LIVE = 2'd1;
	localparam logic [1:0] FLAG_TOMB = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_REMOVED = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;
	localparam logic [2:0] ST_COUNT = 3'd6;

	typedef struct packed {
		logic [1:0] flag;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t wr_data;
	} mem_req_t;

	// (a + b) mod n for a, b already below n
	function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
		input logic [SIZE_W-1:0] b, input logic [SIZE_W-1:0] n);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[SIZE_W-1:0];
	endfunction
endpackage

### src/oaht_mem.sv
// Slot storage: one synchronous RAM of flag/key/value plus per-slot valid bits.
// Depends on oaht_pkg. Read data is registered.
module oaht_mem (
	input  logic clk,
	input  logic arst_n,
	input  oaht_pkg::mem_req_t req,
	output oaht_pkg::entry_t rd_data
);
	oaht_pkg::entry_t ram [oaht_pkg::TABLE_DEPTH];
	logic [oaht_pkg::TABLE_DEPTH-1:0] valid_q;
	oaht_pkg::entry_t ram_rd_q;
	logic rd_valid_q;

	// RAM array, no reset
	always_ff @(posedge clk) begin
		if (req.wr_en)
			ram[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			ram_rd_q <= ram[req.rd_addr];
	end

	// valid bits: a slot never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en)
				valid_q[req.wr_addr] <= 1'b1;
			if (req.rd_en)
				rd_valid_q <= valid_q[req.rd_addr];
		end
	end

	always_comb begin
		rd_data = ram_rd_q;
		if (!rd_valid_q)
			rd_data.flag = oaht_pkg::FLAG_EMPTY;
	end
endmodule

### src/oaht_ctrl.sv
// Operation sequencer: serial key-mod-size divider, probe walk, result register.
// Depends on oaht_pkg; drives the request port of oaht_mem.
module oaht_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [71:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data,
	output oaht_pkg::mem_req_t req,
	input  oaht_pkg::entry_t rd_data
);
	localparam int SW = oaht_pkg::SIZE_W;
	localparam int IW = oaht_pkg::IDX_W;

	typedef enum logic [2:0] {IDLE, DIV, RD, EVAL, FIN} state_t;

	state_t state_q;
	logic [SW-1:0] size_q, n_eff, count_q;
	logic [1:0] mode_q;
	logic [oaht_pkg::KEY_W-1:0] key_q, kshift_q;
	logic [oaht_pkg::VAL_W-1:0] val_q;
	logic [4:0] cnt_q;
	logic [SW-1:0] rem_q, div_t, div_r;
	logic [IW-1:0] pos_q, home_q;
	logic [SW-1:0] sq_q, inc_q, two_n, pos_nx, probes_q;
	logic [2:0] res_st_q;
	logic [IW-1:0] res_slot_q;
	logic out_valid_q;
	logic [2:0] out_st_q;
	logic [IW-1:0] out_slot_q;
	logic [SW-1:0] out_cnt_q;
	logic key_hit, is_live;

	// effective size saturated into 1..depth
	always_comb begin
		if (size_q == '0)
			n_eff = SW'(1);
		else if (size_q > SW'(oaht_pkg::TABLE_DEPTH))
			n_eff = SW'(oaht_pkg::TABLE_DEPTH);
		else
			n_eff = size_q;
		two_n = (n_eff <= SW'(2)) ? '0 : SW'(2);
	end

	// one restoring divide step
	always_comb begin
		div_t = {rem_q[SW-2:0], kshift_q[oaht_pkg::KEY_W-1]};
		div_r = (div_t >= n_eff) ? div_t - n_eff : div_t;
	end

	assign pos_nx = oaht_pkg::mod_add({1'b0, pos_q}, sq_q, n_eff);
	assign is_live = rd_data.flag == oaht_pkg::FLAG_LIVE;
	assign key_hit = rd_data.key == key_q;

	assign s_tready = state_q == IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_cnt_q, out_slot_q, out_st_q};

	// memory requests
	always_comb begin
		req = '0;
		req.rd_en = state_q == RD;
		req.rd_addr = pos_q;
		req.wr_addr = pos_q;
		req.wr_data.flag = oaht_pkg::FLAG_LIVE;
		req.wr_data.key = key_q;
		req.wr_data.value = val_q;
		if (state_q == EVAL) begin
			if (mode_q == oaht_pkg::MODE_INSERT) begin
				req.wr_en = is_live ? key_hit : rd_data.flag == oaht_pkg::FLAG_EMPTY;
			end else begin
				req.wr_en = is_live && key_hit;
				req.wr_data = '0;
				req.wr_data.flag = oaht_pkg::FLAG_TOMB;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			size_q <= SW'(oaht_pkg::TABLE_DEPTH);
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				size_q <= cfg_data;
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						mode_q <= s_tdata[1:0];
						key_q <= s_tdata[32:2];
						kshift_q <= s_tdata[32:2];
						val_q <= s_tdata[64:33];
						rem_q <= '0;
						cnt_q <= 5'd30;
						res_st_q <= oaht_pkg::ST_COUNT;
						res_slot_q <= '0;
						if (s_tdata[1:0] == oaht_pkg::MODE_INSERT ||
							s_tdata[1:0] == oaht_pkg::MODE_REMOVE)
							state_q <= DIV;
						else
							state_q <= FIN;
					end
				end
				DIV: begin
					rem_q <= div_r;
					kshift_q <= {kshift_q[oaht_pkg::KEY_W-2:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						pos_q <= div_r[IW-1:0];
						home_q <= div_r[IW-1:0];
						sq_q <= (n_eff == SW'(1)) ? '0 : SW'(1);
						inc_q <= (n_eff == SW'(1) || n_eff == SW'(3)) ? '0 :
							(n_eff == SW'(2)) ? SW'(1) : SW'(3);
						probes_q <= '0;
						state_q <= RD;
					end
				end
				RD: state_q <= EVAL;
				EVAL: begin
					state_q <= FIN;
					res_slot_q <= pos_q;
					if (mode_q == oaht_pkg::MODE_INSERT && !is_live) begin
						if (rd_data.flag == oaht_pkg::FLAG_EMPTY) begin
							res_st_q <= oaht_pkg::ST_INSERTED;
							count_q <= count_q + SW'(1);
						end else
							res_st_q <= oaht_pkg::ST_BLOCKED;
					end else if (mode_q == oaht_pkg::MODE_INSERT && key_hit) begin
						res_st_q <= oaht_pkg::ST_UPDATED;
					end else if (mode_q != oaht_pkg::MODE_INSERT &&
						rd_data.flag == oaht_pkg::FLAG_EMPTY) begin
						res_st_q <= oaht_pkg::ST_NOTFOUND;
						res_slot_q <= '0;
					end else if (mode_q != oaht_pkg::MODE_INSERT && is_live && key_hit) begin
						res_st_q <= oaht_pkg::ST_REMOVED;
						count_q <= count_q - SW'(1);
					end else if (pos_nx[IW-1:0] == home_q || probes_q + SW'(1) == n_eff) begin
						// walk exhausted
						res_st_q <= (mode_q == oaht_pkg::MODE_INSERT) ?
							oaht_pkg::ST_FULL : oaht_pkg::ST_NOTFOUND;
						res_slot_q <= '0;
					end else begin
						pos_q <= pos_nx[IW-1:0];
						sq_q <= oaht_pkg::mod_add(sq_q, inc_q, n_eff);
						inc_q <= oaht_pkg::mod_add(inc_q, two_n, n_eff);
						probes_q <= probes_q + SW'(1);
						state_q <= RD;
					end
				end
				FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_st_q <= res_st_q;
						out_slot_q <= res_slot_q;
						out_cnt_q <= count_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### src/open_address_hash_table_unit.sv
// Top level of the open-address hash table; each probe steps on by the next square.
// Depends on oaht_pkg, oaht_mem and oaht_ctrl.
//
// Usage:
//  s_ axis channel carries one operation item: mode, key, value.
//  m_ axis channel returns exactly one result item per operation:
//  status, slot, occupied count.
//  cfg channel writes table_size (slots in use, hash divisor); it is always
//  ready and must only be written while no operation is in flight.
// Sequence after acceptance: a count query goes straight to loading the output
//  register; insert and remove first run the serial key-mod-size divider, then
//  per probe a slot RAM read then evaluate and write back, then load the output
//  register.
// Throughput: one item at a time; the next item is accepted the cycle after
//  the result loads the output register.
// Reset: all slots read as empty through per-slot valid bits cleared by
//  arst_n, count zero, table_size 128. No clearing pass is needed.
// Stall: a held result sits in the output register; the sequencer can
//  finish the next item and then waits until the result is taken.
module open_address_hash_table_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [71:0] s_tdata, // mode[1:0], key[32:2], value[64:33], zero pad
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata, // status[2:0], slot[9:3], occupied_count[17:10], pad
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data
);
	oaht_pkg::mem_req_t req;
	oaht_pkg::entry_t rd_data;

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.req(req), .rd_data(rd_data)
	);

	oaht_mem u_mem (
		.clk(clk), .arst_n(arst_n), .req(req), .rd_data(rd_data)
	);
endmodule

### src/oaht_chk.sv
// Port-level checker for the hash table top level, with its bind.
// Depends on assert_macros.svh and oaht_pkg.
`include "assert_macros.svh"
module oaht_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [71:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [7:0] cfg_data
);
	logic no_slot;

	// results that carry no slot
	assign no_slot = m_tdata[2:0] == oaht_pkg::ST_FULL ||
		m_tdata[2:0] == oaht_pkg::ST_NOTFOUND || m_tdata[2:0] == oaht_pkg::ST_COUNT;

	`AST_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`AST_IMPL(a_status, clk, arst_n, m_tvalid, m_tdata[2:0] <= oaht_pkg::ST_COUNT)
	`AST_IMPL(a_slot0, clk, arst_n, m_tvalid && no_slot, m_tdata[9:3] == 7'd0)
	`AST_IMPL(a_cnt, clk, arst_n, m_tvalid, m_tdata[17:10] <= 8'd128)
endmodule

bind open_address_hash_table_unit oaht_chk u_chk (.*);
